>>> hdl/rsg_pkg.sv
// Shared types and constants for the scanline run segmenter.
// Used by every module in hdl/ but rsg_ram. Depends on nothing else.
package rsg_pkg;

  localparam int LINES_PER_FRAME = 240;
  localparam int PALETTE_ENTRIES = 256;
  localparam int PAL_AW          = $clog2(PALETTE_ENTRIES);
  localparam int PAL_W           = 24;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;

  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);

  localparam logic OPC_PIXEL   = 1'b0;
  localparam logic OPC_PALETTE = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_PIXELS_PER_LINE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PIXEL_WIDTH     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_SCALE       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_X_ORIGIN        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_Y_ORIGIN        = 3'd4;

  typedef struct packed {
    logic [8:0]  pixels_per_line;
    logic [4:0]  pixel_width;
    logic [4:0]  row_scale;
    logic [11:0] x_origin;
    logic [11:0] y_origin;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    pixels_per_line: 9'd320,
    pixel_width:     5'd2,
    row_scale:       5'd2,
    x_origin:        12'd0,
    y_origin:        12'd0
  };

  typedef struct packed {
    logic        opcode;
    logic [7:0]  pixel_index;
    logic [23:0] palette_color;
  } in_item_t;

  typedef struct packed {
    logic [11:0] x_start;
    logic [11:0] x_end;
    logic [11:0] y_top;
    logic [4:0]  rows;
    logic [23:0] color;
    logic        end_of_line;
    logic        end_of_frame;
    logic        last;
  } out_item_t;

  // Up to two segments per pixel, packed so seg0 is always the first one.
  typedef struct packed {
    logic      v0;
    logic      v1;
    out_item_t seg0;
    out_item_t seg1;
  } push_t;

endpackage

>>> hdl/rsg_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rsg_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> hdl/rsg_seg_core.sv
// Run tracking and segment building: one looked-up pixel per cycle, unless held.
// Depends on rsg_pkg; takes palette read data from the RAM.
module rsg_seg_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  rsg_pkg::cfg_t                 cfg,
  input  logic                          pix_take,
  input  logic                          pix_idx_ok,
  input  logic [rsg_pkg::PAL_W-1:0]     pal_rdata,
  input  logic                          room,
  output logic                          hold,
  output rsg_pkg::push_t                push
);

  logic        s1_valid_r, s1_valid_nxt;
  logic        s1_idx_ok_r;
  logic [23:0] run_color_r, run_color_nxt;
  logic [11:0] run_start_r, run_start_nxt;
  logic [8:0]  col_r, col_nxt;
  logic [7:0]  line_r, line_nxt;
  logic [11:0] rowpos_r, rowpos_nxt;

  logic        advance;
  logic [23:0] c;
  logic [13:0] prod;
  logic [11:0] pos, end_pos;
  logic        first, change, eol, eof;
  logic [8:0]  ncol;
  logic [8:0]  line_inc;
  logic [4:0]  eff_rows;
  logic [11:0] rs;
  logic [23:0] rc;

  assign advance = s1_valid_r && room;
  assign hold    = s1_valid_r && !room;

  assign c        = s1_idx_ok_r ? pal_rdata : '0;
  assign prod     = {5'd0, col_r} * {9'd0, cfg.pixel_width};
  assign pos      = prod[11:0];
  assign end_pos  = pos + {7'd0, cfg.pixel_width};
  assign first    = (col_r == 9'd0);
  assign change   = !first && (c != run_color_r);
  assign ncol     = col_r + 9'd1;
  assign eol      = (ncol >= cfg.pixels_per_line) || (ncol == 9'd0);
  assign line_inc = {1'b0, line_r} + 9'd1;
  assign eof      = (line_inc >= 9'(rsg_pkg::LINES_PER_FRAME));
  assign eff_rows = (cfg.row_scale == 5'd0) ? 5'd1 : cfg.row_scale;
  assign rs       = first ? 12'd0 : (change ? pos : run_start_r);
  assign rc       = (first || change) ? c : run_color_r;

  always_comb begin
    rsg_pkg::out_item_t seg_a, seg_b;
    seg_a.x_start      = cfg.x_origin + run_start_r;
    seg_a.x_end        = cfg.x_origin + pos;
    seg_a.y_top        = cfg.y_origin + rowpos_r;
    seg_a.rows         = eff_rows;
    seg_a.color        = run_color_r;
    seg_a.end_of_line  = 1'b0;
    seg_a.end_of_frame = 1'b0;
    seg_a.last         = !eol;

    seg_b.x_start      = cfg.x_origin + rs;
    seg_b.x_end        = cfg.x_origin + end_pos;
    seg_b.y_top        = cfg.y_origin + rowpos_r;
    seg_b.rows         = eff_rows;
    seg_b.color        = rc;
    seg_b.end_of_line  = 1'b1;
    seg_b.end_of_frame = eof;
    seg_b.last         = 1'b1;

    push.v0   = advance && (change || eol);
    push.v1   = advance && change && eol;
    push.seg0 = change ? seg_a : seg_b;
    push.seg1 = seg_b;
  end

  always_comb begin
    s1_valid_nxt  = pix_take || (s1_valid_r && !advance);
    col_nxt       = col_r;
    run_start_nxt = run_start_r;
    run_color_nxt = run_color_r;
    line_nxt      = line_r;
    rowpos_nxt    = rowpos_r;
    if (advance) begin
      run_color_nxt = rc;
      if (eol) begin
        col_nxt       = 9'd0;
        run_start_nxt = 12'd0;
        if (eof) begin
          line_nxt   = 8'd0;
          rowpos_nxt = 12'd0;
        end else begin
          line_nxt   = line_inc[7:0];
          rowpos_nxt = rowpos_r + {7'd0, eff_rows};
        end
      end else begin
        col_nxt       = ncol;
        run_start_nxt = rs;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      col_r       <= '0;
      run_start_r <= '0;
      run_color_r <= '0;
      line_r      <= '0;
      rowpos_r    <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      col_r       <= col_nxt;
      run_start_r <= run_start_nxt;
      run_color_r <= run_color_nxt;
      line_r      <= line_nxt;
      rowpos_r    <= rowpos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pix_take) begin
      s1_idx_ok_r <= pix_idx_ok;
    end
  end

endmodule

>>> hdl/rsg_out_queue.sv
// Four-entry result queue taking up to two segments per cycle.
// Depends on rsg_pkg.
module rsg_out_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  rsg_pkg::push_t      push,
  output logic                room,
  output logic                out_valid,
  input  logic                out_stall,
  output rsg_pkg::out_item_t  out_data
);

  rsg_pkg::out_item_t q_r [rsg_pkg::Q_DEPTH];
  logic [rsg_pkg::Q_AW-1:0] rptr_r, rptr_nxt, wptr_r, wptr_nxt, wptr_b;
  logic [rsg_pkg::Q_CW-1:0] count_r, count_nxt;
  logic                     pop;
  logic [rsg_pkg::Q_CW-1:0] n_push;

  assign out_valid = (count_r != '0);
  assign out_data  = q_r[rptr_r];
  assign pop       = out_valid && !out_stall;
  assign room      = (count_r <= rsg_pkg::Q_CW'(rsg_pkg::Q_DEPTH - 2));
  assign n_push    = rsg_pkg::Q_CW'(push.v0) + rsg_pkg::Q_CW'(push.v1);
  assign wptr_b    = wptr_r + rsg_pkg::Q_AW'(1);

  assign rptr_nxt  = pop ? rptr_r + rsg_pkg::Q_AW'(1) : rptr_r;
  assign wptr_nxt  = wptr_r + n_push[rsg_pkg::Q_AW-1:0];
  assign count_nxt = count_r + n_push - rsg_pkg::Q_CW'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rptr_r  <= '0;
      wptr_r  <= '0;
      count_r <= '0;
    end else begin
      rptr_r  <= rptr_nxt;
      wptr_r  <= wptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.v0) begin
      q_r[wptr_r] <= push.seg0;
    end
    if (push.v1) begin
      q_r[wptr_b] <= push.seg1;
    end
  end

endmodule

>>> hdl/scanline_run_segmenter.sv
// Scanline run segmenter: palette writes and pixel indices in, run segments out.
// Depends on rsg_pkg, rsg_ram, rsg_seg_core and rsg_out_queue.
//
// One input transfer is taken every cycle while the input is not stalled. A
// pixel is looked up in the palette RAM on the cycle it is taken and its
// segments are built in the next, then pushed when the queue has room. A
// pixel gives zero, one or two segments (two when the colour changes on the
// last pixel of a line); they enter a four-entry output queue. The input
// stalls only while a looked-up pixel waits for two free queue places. A
// palette write gives no segment. Palette entries read before being written
// return undefined colours.
module scanline_run_segmenter (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [rsg_pkg::CFG_IDX_W-1:0]      cfg_idx,
  input  logic [rsg_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  rsg_pkg::in_item_t                  in_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output rsg_pkg::out_item_t                 out_data
);

  rsg_pkg::cfg_t  cfg_r, cfg_nxt;
  rsg_pkg::push_t push;
  logic           in_acc, idx_ok, hold, room;
  logic           pal_we, pal_re;
  logic [rsg_pkg::PAL_W-1:0] pal_rdata;

  assign in_acc   = in_valid && !in_stall;
  assign in_stall = hold;
  assign idx_ok   = ({1'b0, in_data.pixel_index} < 9'(rsg_pkg::PALETTE_ENTRIES));
  assign pal_we   = in_acc && (in_data.opcode == rsg_pkg::OPC_PALETTE) && idx_ok;
  assign pal_re   = in_acc && (in_data.opcode == rsg_pkg::OPC_PIXEL);

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_idx)
        rsg_pkg::REG_PIXELS_PER_LINE: cfg_nxt.pixels_per_line = cfg_wdata[8:0];
        rsg_pkg::REG_PIXEL_WIDTH:     cfg_nxt.pixel_width     = cfg_wdata[4:0];
        rsg_pkg::REG_ROW_SCALE:       cfg_nxt.row_scale       = cfg_wdata[4:0];
        rsg_pkg::REG_X_ORIGIN:        cfg_nxt.x_origin        = cfg_wdata[11:0];
        rsg_pkg::REG_Y_ORIGIN:        cfg_nxt.y_origin        = cfg_wdata[11:0];
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= rsg_pkg::CFG_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  rsg_ram #(
    .WIDTH(rsg_pkg::PAL_W),
    .DEPTH(rsg_pkg::PALETTE_ENTRIES)
  ) u_palette (
    .clk   (clk),
    .we    (pal_we),
    .waddr (in_data.pixel_index[rsg_pkg::PAL_AW-1:0]),
    .wdata (in_data.palette_color),
    .re    (pal_re),
    .raddr (in_data.pixel_index[rsg_pkg::PAL_AW-1:0]),
    .rdata (pal_rdata)
  );

  rsg_seg_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .pix_take   (pal_re),
    .pix_idx_ok (idx_ok),
    .pal_rdata  (pal_rdata),
    .room       (room),
    .hold       (hold),
    .push       (push)
  );

  rsg_out_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

>>> sim/rsg_scoreboard_pkg.sv
// Scoreboard for the scanline run segmenter: register copy, palette, run
// state and a queue of predicted segments. Depends on rsg_pkg.
package rsg_scoreboard_pkg;
  import rsg_pkg::*;

  class segment_scoreboard;
    cfg_t        regs;
    logic [23:0] palette [PALETTE_ENTRIES];
    logic [23:0] run_colour;
    logic [11:0] run_start;
    logic [8:0]  column;
    logic [7:0]  line;
    logic [11:0] row_pos;
    out_item_t   expected_segs[$];
    int          mismatches;
    int          transfers_in;
    int          segments_out;
    int          line_ends;
    int          frame_ends;

    function new();
      regs         = CFG_RESET;
      run_colour   = '0;
      run_start    = '0;
      column       = '0;
      line         = '0;
      row_pos      = '0;
      mismatches   = 0;
      transfers_in = 0;
      segments_out = 0;
      line_ends    = 0;
      frame_ends   = 0;
      foreach (palette[i]) palette[i] = '0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        REG_PIXELS_PER_LINE: regs.pixels_per_line = value[8:0];
        REG_PIXEL_WIDTH:     regs.pixel_width     = value[4:0];
        REG_ROW_SCALE:       regs.row_scale       = value[4:0];
        REG_X_ORIGIN:        regs.x_origin        = value;
        REG_Y_ORIGIN:        regs.y_origin        = value;
        default: ;
      endcase
    endfunction

    function logic [4:0] rows_per_line();
      return (regs.row_scale == 0) ? 5'd1 : regs.row_scale;
    endfunction

    function out_item_t make_segment(logic [11:0] xs_off, logic [11:0] xe_off,
                                     logic [23:0] colour, logic eol, logic eof);
      out_item_t s;
      s.x_start      = regs.x_origin + xs_off;
      s.x_end        = regs.x_origin + xe_off;
      s.y_top        = regs.y_origin + row_pos;
      s.rows         = rows_per_line();
      s.color        = colour;
      s.end_of_line  = eol;
      s.end_of_frame = eof;
      s.last         = 1'b0;
      return s;
    endfunction

    function void note_input(in_item_t it);
      out_item_t   segs [2];
      int          n;
      logic [23:0] c;
      int unsigned prod;
      logic [11:0] pos;
      logic        eof;
      transfers_in++;
      if (it.opcode == OPC_PALETTE) begin
        palette[it.pixel_index] = it.palette_color;
        return;
      end
      n    = 0;
      c    = palette[it.pixel_index];
      prod = column * regs.pixel_width;
      pos  = prod[11:0];
      if (column == 0) begin
        run_colour = c;
        run_start  = '0;
      end else if (c != run_colour) begin
        segs[n]    = make_segment(run_start, pos, run_colour, 1'b0, 1'b0);
        n          = n + 1;
        run_start  = pos;
        run_colour = c;
      end
      column = column + 9'd1;
      if (column >= regs.pixels_per_line || column == 0) begin
        prod    = ((column == 0) ? 512 : column) * regs.pixel_width;
        eof     = (int'(line) + 1 >= LINES_PER_FRAME);
        segs[n] = make_segment(run_start, prod[11:0], run_colour, 1'b1, eof);
        n       = n + 1;
        line_ends++;
        column    = '0;
        run_start = '0;
        if (eof) begin
          frame_ends++;
          line    = '0;
          row_pos = '0;
        end else begin
          line    = line + 8'd1;
          row_pos = row_pos + rows_per_line();
        end
      end
      if (n > 0) segs[n-1].last = 1'b1;
      for (int i = 0; i < n; i++) expected_segs.push_back(segs[i]);
    endfunction

    function string describe(out_item_t s);
      return $sformatf("x %0d..%0d y %0d rows %0d colour %06h eol %0b eof %0b last %0b",
                       s.x_start, s.x_end, s.y_top, s.rows, s.color,
                       s.end_of_line, s.end_of_frame, s.last);
    endfunction

    function void flag_error(string msg);
      mismatches++;
      if (mismatches <= 10) $display("MISMATCH: %s", msg);
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      string     bad;
      segments_out++;
      if (expected_segs.size() == 0) begin
        flag_error({"segment with none outstanding: ", describe(got)});
        return;
      end
      want = expected_segs.pop_front();
      bad  = "";
      if (got.x_start !== want.x_start)           bad = {bad, " x_start"};
      if (got.x_end !== want.x_end)               bad = {bad, " x_end"};
      if (got.y_top !== want.y_top)               bad = {bad, " y_top"};
      if (got.rows !== want.rows)                 bad = {bad, " rows"};
      if (got.color !== want.color)               bad = {bad, " color"};
      if (got.end_of_line !== want.end_of_line)   bad = {bad, " end_of_line"};
      if (got.end_of_frame !== want.end_of_frame) bad = {bad, " end_of_frame"};
      if (got.last !== want.last)                 bad = {bad, " last"};
      if (bad != "")
        flag_error($sformatf("segment %0d wrong in%s; expected %s; actual %s",
                             segments_out, bad, describe(want), describe(got)));
    endfunction

    function void close_out();
      if (expected_segs.size() != 0)
        flag_error($sformatf("%0d segments never arrived", expected_segs.size()));
    endfunction
  endclass

endpackage

>>> sim/scanline_run_segmenter_test.sv
// Testbench for scanline_run_segmenter: drives palette writes and pixels,
// predicts segments with the scoreboard class. Depends on rsg_pkg, rsg_scoreboard_pkg.
module scanline_run_segmenter_test;
  import rsg_pkg::*;
  import rsg_scoreboard_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int          SETTLE_CYCLES = 10;
  localparam int unsigned CYCLE_LIMIT   = 250000;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  in_valid;
  logic                  in_stall;
  in_item_t              in_data;
  logic                  out_valid;
  logic                  out_stall;
  out_item_t             out_data;

  segment_scoreboard sb;
  bit                quiet   = 1'b0;
  int                rx_hold = 0;
  int                settings_used = 0;
  int unsigned       cycle_count = 0;
  bit                is_used [256];
  logic [7:0]        used_idx[$];
  logic [7:0]        last_idx = '0;

  scanline_run_segmenter DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic in_item_t palette_item(logic [7:0] idx, logic [23:0] colour);
    in_item_t it;
    it.opcode        = OPC_PALETTE;
    it.pixel_index   = idx;
    it.palette_color = colour;
    if (!is_used[idx]) begin
      is_used[idx] = 1'b1;
      used_idx.push_back(idx);
    end
    return it;
  endfunction

  function automatic in_item_t pixel_item(logic [7:0] idx);
    in_item_t it;
    it.opcode        = OPC_PIXEL;
    it.pixel_index   = idx;
    it.palette_color = 24'($urandom);
    last_idx         = idx;
    return it;
  endfunction

  // often repeats of the last index, with palette writes mixed in
  function automatic in_item_t make_item();
    int          pick;
    logic [7:0]  idx;
    logic [23:0] colour;
    pick = $urandom_range(0, 99);
    if (pick < 12) begin
      idx = 8'($urandom_range(0, 255));
      case ($urandom_range(0, 3))
        0:       colour = sb.palette[used_idx[$urandom_range(0, used_idx.size() - 1)]];
        1:       colour = $urandom_range(0, 1) ? 24'hFFFFFF : 24'h000000;
        default: colour = 24'($urandom);
      endcase
      return palette_item(idx, colour);
    end
    if (pick < 60) return pixel_item(last_idx);
    return pixel_item(used_idx[$urandom_range(0, used_idx.size() - 1)]);
  endfunction

  task automatic send_item(input in_item_t item);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    sb.note_input(item);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (sb.expected_segs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= CFG_DATA_W'(value);
    @(posedge clk);
    sb.set_reg(idx, CFG_DATA_W'(value));
  endtask

  task automatic write_config(input int ppl, input int pw, input int rs,
                              input int xo, input int yo);
    put_reg(REG_PIXELS_PER_LINE, ppl);
    put_reg(REG_PIXEL_WIDTH, pw);
    put_reg(REG_ROW_SCALE, rs);
    put_reg(REG_X_ORIGIN, xo);
    put_reg(REG_Y_ORIGIN, yo);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  task automatic run_phase(input int ppl, input int pw, input int rs, input int xo,
                           input int yo, input int count, input bit squeeze);
    settle();
    write_config(ppl, pw, rs, xo, yo);
    if (squeeze) rx_hold = 300;
    for (int k = 0; k < count; k++) begin
      if (k % 40 == 0) quiet = (squeeze && k < 120) ? 1'b1 : ($urandom_range(0, 3) == 0);
      send_item(make_item());
    end
    quiet = 1'b0;
  endtask

  initial begin : result_sink
    int wait_cycles;
    out_stall <= 1'b0;
    @(posedge clk);
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (rx_hold > 0) begin
        wait_cycles = rx_hold;
        rx_hold     = 0;
      end else begin
        wait_cycles = quiet ? 0 : $urandom_range(0, 10);
      end
      if (wait_cycles > 0) begin
        out_stall <= 1'b1;
        repeat (wait_cycles) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (out_valid !== 1'b1) @(posedge clk);
      sb.check_result(out_data);
    end
  end

  initial begin
    sb = new();
    rst_n     <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_idx   <= REG_PIXELS_PER_LINE;
    cfg_wdata <= '0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // short lines; colour change on last pixel, equal colours from different
    // entries, palette rewrite mid-stream, coordinates wrapping past 4095
    settle();
    write_config(3, 16, 16, 4095, 4095);
    send_item(palette_item(8'h00, 24'h000000));
    send_item(palette_item(8'hFF, 24'hFFFFFF));
    send_item(palette_item(8'h55, 24'hAAAAAA));
    send_item(palette_item(8'hAA, 24'h555555));
    send_item(palette_item(8'h01, 24'hFFFFFF));
    send_item(pixel_item(8'h00));
    send_item(pixel_item(8'h00));
    send_item(pixel_item(8'hFF));
    send_item(pixel_item(8'hFF));
    send_item(pixel_item(8'h01));
    send_item(pixel_item(8'h01));
    send_item(pixel_item(8'h55));
    send_item(pixel_item(8'hAA));
    send_item(pixel_item(8'h55));
    send_item(palette_item(8'h55, 24'h000000));
    send_item(pixel_item(8'h00));
    send_item(pixel_item(8'h55));
    send_item(pixel_item(8'hFF));
    send_item(pixel_item(8'hAA));
    send_item(pixel_item(8'hAA));

    // line left part-way: the next phase's shorter line ends on its first pixel
    run_phase(1, 1, 1, 0, 0, 300, 1'b0);
    run_phase(0, 0, 0, $urandom_range(0, 4095), $urandom_range(0, 4095), 120, 1'b0);
    run_phase(320, 2, 2, 0, 0, 150, 1'b0);
    run_phase(5, 16, 16, 4095, 4000, 200, 1'b1);
    run_phase(2, 3, 16, 10, 3000, 450, 1'b0);
    run_phase($urandom_range(1, 20), $urandom_range(1, 16), $urandom_range(1, 16),
              $urandom_range(0, 4095), $urandom_range(0, 4095), 150, 1'b0);

    settle();
    sb.close_out();
    $display("Run covered %0d input transfers and %0d segments over %0d register settings,",
             sb.transfers_in, sb.segments_out, settings_used);
    $display("with %0d line ends and %0d frame ends; %0d mismatches.",
             sb.line_ends, sb.frame_ends, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

>>> files.f
hdl/rsg_pkg.sv
hdl/rsg_ram.sv
hdl/rsg_seg_core.sv
hdl/rsg_out_queue.sv
hdl/scanline_run_segmenter.sv
sim/rsg_scoreboard_pkg.sv
sim/scanline_run_segmenter_test.sv
